[hw/rtl/assert_macros.svh]
// assertion helpers shared by the touch report decoder modules
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[hw/rtl/trd_pkg.sv]
// types and constants of the touch report decoder
// used by trd_lane and touch_report_decoder, no dependencies
package trd_pkg;

	// report framing
	localparam logic [3:0] REPORT_LEN       = 4'd5;
	localparam int         STATUS_VALID_BIT = 7;
	localparam int         STATUS_TOUCH_BIT = 0;

	// item kinds
	localparam logic ITEM_REPORT  = 1'b0;
	localparam logic ITEM_TIMEOUT = 1'b1;

	// event codes
	localparam logic [1:0] EV_PRESS   = 2'd0;
	localparam logic [1:0] EV_RELEASE = 2'd1;
	localparam logic [1:0] EV_MOTION  = 2'd2;

	// register indexes
	localparam logic [2:0] REG_CAL_LEFT      = 3'd0;
	localparam logic [2:0] REG_CAL_TOP       = 3'd1;
	localparam logic [2:0] REG_CAL_RIGHT     = 3'd2;
	localparam logic [2:0] REG_CAL_BOTTOM    = 3'd3;
	localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd4;
	localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd5;
	localparam logic [2:0] REG_CALIBRATING   = 3'd6;

	// register reset values
	localparam logic [15:0] RST_CAL_LEFT      = 16'd100;
	localparam logic [15:0] RST_CAL_TOP       = 16'd290;
	localparam logic [15:0] RST_CAL_RIGHT     = 16'd3696;
	localparam logic [15:0] RST_CAL_BOTTOM    = 16'd3621;
	localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd800;
	localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd480;

	// divider geometry: 13-bit size times 16-bit offset magnitude
	localparam int DVD_W     = 29;
	localparam int DIV_STEPS = DVD_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		LN_IDLE,
		LN_MUL,
		LN_DIV,
		LN_DONE
	} lane_state_t;

	// control from the merge stage to a lane
	typedef struct packed {
		logic start;
		logic ack;
	} lane_ctl_t;

	// status from a lane to the merge stage
	typedef struct packed {
		logic busy;
		logic done;
	} lane_sts_t;

endpackage

[hw/rtl/touch_report_decoder.sv]
// touch report decoder: an accepted result item runs through the multiply state, 29 divide steps
// and one output load, with the divide skipped in a lane whose span is zero; no new item is taken
// until the output load, and a held output beat stalls the input
// items that give no result are taken every cycle while the lanes are idle
// reset clears tracking, last point, output valid and restores calibration defaults
// depends on trd_pkg, trd_lane and assert_macros.svh
`include "assert_macros.svh"

module touch_report_decoder import trd_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               item_kind,
	input  logic [3:0]         report_length,
	input  logic [7:0]         status_byte,
	input  logic [15:0]        raw_x,
	input  logic [15:0]        raw_y,
	// output channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         touch_event,
	output logic signed [15:0] screen_x,
	output logic signed [15:0] screen_y,
	output logic signed [16:0] delta_x,
	output logic signed [16:0] delta_y,
	output logic [15:0]        last_raw_x,
	output logic [15:0]        last_raw_y
);

	logic [15:0] cal_left_q, cal_top_q, cal_right_q, cal_bottom_q;
	logic [12:0] screen_width_q, screen_height_q;
	logic        calibrating_q;

	logic        tracking_q;
	logic [15:0] prev_x_q, prev_y_q;
	logic        busy_q;
	logic [1:0]  pend_event_q;
	logic [16:0] pend_dx_q, pend_dy_q;

	logic        out_valid_q;
	logic [1:0]  touch_event_q;
	logic [15:0] screen_x_q, screen_y_q;
	logic [16:0] delta_x_q, delta_y_q;
	logic [15:0] last_raw_x_q, last_raw_y_q;

	logic        accept, valid_rep, timeout_rel, emit, touched, start, load;
	logic        trk_d;
	logic [1:0]  ev_d;
	logic [16:0] dx_d, dy_d;
	logic [15:0] point_x, point_y;

	lane_ctl_t   lane_ctl;
	lane_sts_t   x_sts, y_sts;
	logic [15:0] x_coord, y_coord;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_left_q      <= RST_CAL_LEFT;
			cal_top_q       <= RST_CAL_TOP;
			cal_right_q     <= RST_CAL_RIGHT;
			cal_bottom_q    <= RST_CAL_BOTTOM;
			screen_width_q  <= RST_SCREEN_WIDTH;
			screen_height_q <= RST_SCREEN_HEIGHT;
			calibrating_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAL_LEFT:      cal_left_q      <= cfg_data;
				REG_CAL_TOP:       cal_top_q       <= cfg_data;
				REG_CAL_RIGHT:     cal_right_q     <= cfg_data;
				REG_CAL_BOTTOM:    cal_bottom_q    <= cfg_data;
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[12:0];
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data[12:0];
				REG_CALIBRATING:   calibrating_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// report decode and event selection
	always_comb begin
		valid_rep   = (item_kind == ITEM_REPORT) && (report_length == REPORT_LEN)
			&& status_byte[STATUS_VALID_BIT];
		timeout_rel = (item_kind == ITEM_TIMEOUT) && tracking_q;
		emit        = valid_rep || timeout_rel;
		touched     = status_byte[STATUS_TOUCH_BIT];
		point_x     = valid_rep ? raw_x : prev_x_q;
		point_y     = valid_rep ? raw_y : prev_y_q;
		ev_d        = EV_MOTION;
		trk_d       = tracking_q;
		dx_d        = '0;
		dy_d        = '0;
		priority if (timeout_rel) begin
			ev_d  = EV_RELEASE;
			trk_d = 1'b0;
		end else if (touched && !tracking_q) begin
			ev_d  = EV_PRESS;
			trk_d = 1'b1;
		end else if (!touched && tracking_q) begin
			ev_d  = EV_RELEASE;
			trk_d = 1'b0;
		end else begin
			dx_d = {1'b0, raw_x} - {1'b0, prev_x_q};
			dy_d = {1'b0, raw_y} - {1'b0, prev_y_q};
		end
	end

	// handshake control
	assign in_ready     = !busy_q;
	assign accept       = in_valid && in_ready;
	assign start        = accept && emit;
	assign load         = x_sts.done && y_sts.done && (!out_valid_q || out_ready);
	assign lane_ctl.start = start;
	assign lane_ctl.ack   = load;

	// tracking state and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q  <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				tracking_q <= trk_d;
				busy_q     <= 1'b1;
				if (valid_rep) begin
					prev_x_q <= raw_x;
					prev_y_q <= raw_y;
				end
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// pending beat fields held while the lanes work
	always_ff @(posedge clk) begin
		if (start) begin
			pend_event_q <= ev_d;
			pend_dx_q    <= dx_d;
			pend_dy_q    <= dy_d;
		end
	end

	// axis lanes
	trd_lane #(
		.COORD_BITS(COORD_BITS)
	) u_lane_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (lane_ctl),
		.raw     (point_x),
		.edge_lo (cal_left_q),
		.edge_hi (cal_right_q),
		.size    (screen_width_q),
		.sts     (x_sts),
		.coord   (x_coord)
	);

	trd_lane #(
		.COORD_BITS(COORD_BITS)
	) u_lane_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (lane_ctl),
		.raw     (point_y),
		.edge_lo (cal_top_q),
		.edge_hi (cal_bottom_q),
		.size    (screen_height_q),
		.sts     (y_sts),
		.coord   (y_coord)
	);

	// merge lanes into the output register
	always_ff @(posedge clk) begin
		if (load) begin
			touch_event_q <= pend_event_q;
			screen_x_q    <= calibrating_q ? '0 : x_coord;
			screen_y_q    <= calibrating_q ? '0 : y_coord;
			delta_x_q     <= pend_dx_q;
			delta_y_q     <= pend_dy_q;
			last_raw_x_q  <= prev_x_q;
			last_raw_y_q  <= prev_y_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign touch_event = touch_event_q;
	assign screen_x    = screen_x_q;
	assign screen_y    = screen_y_q;
	assign delta_x     = delta_x_q;
	assign delta_y     = delta_y_q;
	assign last_raw_x  = last_raw_x_q;
	assign last_raw_y  = last_raw_y_q;

	// checks
	`ASSERT_PROP(a_lanes_lockstep, x_sts.busy == y_sts.busy, "axis lanes out of step")
	`ASSERT_PROP(a_busy_lanes, busy_q |-> (x_sts.busy && y_sts.busy), "busy without lanes at work")
	`ASSERT_PROP(a_press_tracks, (load && (pend_event_q == EV_PRESS)) |-> tracking_q, "press beat while not tracking")
	`ASSERT_PROP(a_release_idle, (load && (pend_event_q == EV_RELEASE)) |-> !tracking_q, "release beat while tracking")

endmodule

[hw/rtl/trd_lane.sv]
// one axis lane: offset and span, size multiply, 29-step restoring divide, saturation
// depends on trd_pkg and assert_macros.svh
`include "assert_macros.svh"

module trd_lane import trd_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  lane_ctl_t   ctl,
	input  logic [15:0] raw,
	input  logic [15:0] edge_lo,
	input  logic [15:0] edge_hi,
	input  logic [12:0] size,
	output lane_sts_t   sts,
	output logic [15:0] coord
);

	localparam logic [DVD_W-1:0] MAG_MAX = DVD_W'((64'd1 << (COORD_BITS - 1)) - 64'd1);
	localparam logic [DVD_W-1:0] MAG_MIN = DVD_W'(64'd1 << (COORD_BITS - 1));

	lane_state_t      state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      off_mag_q;
	logic [15:0]      dsr_q;
	logic             neg_q;
	logic             span_zero_q;
	logic [12:0]      size_q;
	logic [DVD_W-1:0] dvd_q;
	logic [15:0]      rem_q;

	logic [16:0]      off_c, span_c;
	logic [16:0]      rem_sh;
	logic             ge;
	logic [DVD_W-1:0] lim;
	logic [15:0]      mag_lim;

	// signed offset and span at start
	assign off_c  = {1'b0, raw} - {1'b0, edge_lo};
	assign span_c = {1'b0, edge_hi} - {1'b0, edge_lo};

	// one restoring divide step
	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign ge     = rem_sh >= {1'b0, dsr_q};

	// saturate the quotient magnitude and apply the sign
	assign lim     = neg_q ? MAG_MIN : MAG_MAX;
	assign mag_lim = (dvd_q > lim) ? lim[15:0] : dvd_q[15:0];
	assign coord   = neg_q ? (16'd0 - mag_lim) : mag_lim;

	assign sts.busy = (state_q != LN_IDLE);
	assign sts.done = (state_q == LN_DONE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LN_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			LN_IDLE: begin
				if (ctl.start) state_d = LN_MUL;
			end
			LN_MUL: begin
				state_d = span_zero_q ? LN_DONE : LN_DIV;
			end
			LN_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = LN_DONE;
			end
			LN_DONE: begin
				if (ctl.ack) state_d = LN_IDLE;
			end
			default: state_d = LN_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			LN_IDLE: begin
				if (ctl.start) begin
					off_mag_q   <= off_c[16] ? 16'(17'd0 - off_c) : off_c[15:0];
					dsr_q       <= span_c[16] ? 16'(17'd0 - span_c) : span_c[15:0];
					neg_q       <= off_c[16] ^ span_c[16];
					span_zero_q <= (span_c == 17'd0);
					size_q      <= size;
				end
			end
			LN_MUL: begin
				dvd_q <= span_zero_q ? '0
					: DVD_W'({16'd0, size_q} * {13'd0, off_mag_q});
				rem_q <= '0;
				cnt_q <= '0;
			end
			LN_DIV: begin
				rem_q <= ge ? 16'(rem_sh - {1'b0, dsr_q}) : rem_sh[15:0];
				dvd_q <= {dvd_q[DVD_W-2:0], ge};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			LN_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// checks
	`ASSERT_PROP(a_rem_bound, (state_q == LN_DIV) |-> (rem_q < dsr_q), "lane remainder not below divisor")
	`ASSERT_PROP(a_start_idle, ctl.start |-> (state_q == LN_IDLE), "lane started while busy")
	`ASSERT_PROP(a_cnt_range, (state_q == LN_DIV) |-> (cnt_q < CNT_W'(DIV_STEPS)), "lane step count overrun")

endmodule
